### design/assert_macros.svh
// Shared assertion macros for the ARQ controller checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### design/arq_pkg.sv
`default_nettype none

package arq_pkg;

    // Default sizes of the internal counters
    localparam int TIMER_BITS_DEF = 16;
    localparam int RETRY_BITS_DEF = 4;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int CMD_W      = 2;
    localparam int TYPE_W     = 8;
    localparam int ID_W       = 64;
    localparam int CFG_RTRY_W = 4;
    localparam int CFG_TICK_W = 16;
    localparam int ATTEMPT_W  = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Event codes
    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_TX_RES = 2'd2;
    localparam logic [OP_W-1:0] OP_RX_PKT = 2'd3;

    // Radio orders
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TX      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RX      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_STANDBY = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_GAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_TYPE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OWN_ID      = 3'd4;

    // Register reset values
    localparam logic [CFG_RTRY_W-1:0] RST_MAX_RETRIES = 4'd3;
    localparam logic [CFG_TICK_W-1:0] RST_ACK_TIMEOUT = 16'd2000;
    localparam logic [CFG_TICK_W-1:0] RST_RETRY_GAP   = 16'd500;
    localparam logic [TYPE_W-1:0]     RST_ACK_TYPE    = 8'd1;
    localparam logic [ID_W-1:0]       RST_OWN_ID      = 64'd0;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic              tx_ok;
        logic              rx_ok;
        logic [TYPE_W-1:0] rx_type;
        logic [ID_W-1:0]   rx_sender_id;
    } t_item;

    typedef struct packed {
        logic [CFG_RTRY_W-1:0] max_retries;
        logic [CFG_TICK_W-1:0] ack_timeout_ticks;
        logic [CFG_TICK_W-1:0] retry_gap_ticks;
        logic [TYPE_W-1:0]     ack_type_code;
        logic [ID_W-1:0]       own_id;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0]     command;
        logic                 done_res;
        logic                 success;
        logic [ATTEMPT_W-1:0] attempt;
    } t_res;

endpackage

`default_nettype wire

### design/ack_retry_transmit_controller.sv
// Stop-and-wait sender controller: each event word (start, 1 ms tick,
// transmit result, received packet) gives exactly one result word with the
// radio order, done/success flags and the current retry number. A word
// accepted into the input register is processed and lands in the result
// register, where its result is valid. A new event word is taken every
// cycle; the input stalls only while a result word waits on the downstream
// stall, so throughput is set only by that stall. Configuration writes act
// at once and are meant to be made while no word is in flight.
`default_nettype none

module ack_retry_transmit_controller
    import arq_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int RETRY_BITS = RETRY_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic                  i_tx_ok,
    input  wire logic                  i_rx_ok,
    input  wire logic [TYPE_W-1:0]     i_rx_type,
    input  wire logic [ID_W-1:0]       i_rx_sender_id,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [CMD_W-1:0]           o_command,
    output logic                       o_done_res,
    output logic                       o_success,
    output logic [ATTEMPT_W-1:0]       o_attempt
);

    t_cfg  cfg;
    t_res  res;
    t_item r_item;
    t_res  r_res;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  advance;
    logic  fire;

    arq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Stage moves when the result register is free or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_item.operation    <= i_operation;
            r_item.tx_ok        <= i_tx_ok;
            r_item.rx_ok        <= i_rx_ok;
            r_item.rx_type      <= i_rx_type;
            r_item.rx_sender_id <= i_rx_sender_id;
        end
    end

    arq_fsm #(
        .TIMER_BITS (TIMER_BITS),
        .RETRY_BITS (RETRY_BITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_command   = r_res.command;
    assign o_done_res  = r_res.done_res;
    assign o_success   = r_res.success;
    assign o_attempt   = r_res.attempt;

endmodule

`default_nettype wire

### design/arq_cfg.sv
`default_nettype none

module arq_cfg
    import arq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_retries       <= RST_MAX_RETRIES;
            r_cfg.ack_timeout_ticks <= RST_ACK_TIMEOUT;
            r_cfg.retry_gap_ticks   <= RST_RETRY_GAP;
            r_cfg.ack_type_code     <= RST_ACK_TYPE;
            r_cfg.own_id            <= RST_OWN_ID;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MAX_RETRIES: r_cfg.max_retries       <= i_cfg_data[CFG_RTRY_W-1:0];
                REG_ACK_TIMEOUT: r_cfg.ack_timeout_ticks <= i_cfg_data[CFG_TICK_W-1:0];
                REG_RETRY_GAP:   r_cfg.retry_gap_ticks   <= i_cfg_data[CFG_TICK_W-1:0];
                REG_ACK_TYPE:    r_cfg.ack_type_code     <= i_cfg_data[TYPE_W-1:0];
                REG_OWN_ID:      r_cfg.own_id            <= i_cfg_data[ID_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/arq_fsm.sv
`default_nettype none

module arq_fsm
    import arq_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int RETRY_BITS = RETRY_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_res       o_res
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_TXWAIT = 2'd1;
    localparam logic [1:0] PH_ACKWIN = 2'd2;
    localparam logic [1:0] PH_GAP    = 2'd3;

    // Compare widths cover both the counter and the register field
    localparam int TW = (TIMER_BITS > CFG_TICK_W) ? TIMER_BITS : CFG_TICK_W;
    localparam int RW = (RETRY_BITS > CFG_RTRY_W) ? RETRY_BITS : CFG_RTRY_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam logic [RW-1:0] RETRY_MAX = RW'({RETRY_BITS{1'b1}});

    logic [1:0]            r_phase,  n_phase;
    logic [RETRY_BITS-1:0] r_retry,  n_retry;
    logic [TIMER_BITS-1:0] r_tick,   n_tick;

    logic [TIMER_BITS-1:0] tick_inc;
    logic [RW-1:0]         retry_lim;
    logic                  exhausted;
    logic                  win_hit;
    logic                  gap_hit;
    logic                  is_ack;

    // Saturating tick and limit checks
    assign tick_inc  = (r_tick == TIMER_MAX) ? r_tick : r_tick + 1'b1;
    assign win_hit   = (TW'(tick_inc) >= TW'(i_cfg.ack_timeout_ticks)) || (tick_inc == TIMER_MAX);
    assign gap_hit   = (TW'(tick_inc) >= TW'(i_cfg.retry_gap_ticks)) || (tick_inc == TIMER_MAX);
    assign retry_lim = (RW'(i_cfg.max_retries) < RETRY_MAX) ? RW'(i_cfg.max_retries) : RETRY_MAX;
    assign exhausted = RW'(r_retry) >= retry_lim;
    assign is_ack    = i_item.rx_ok && (i_item.rx_type == i_cfg.ack_type_code)
                       && (i_item.rx_sender_id == i_cfg.own_id);

    // Next state and result for one event
    always_comb begin
        logic             do_fail;
        logic [CMD_W-1:0] base_cmd;
        do_fail   = 1'b0;
        base_cmd  = CMD_NONE;
        n_phase   = r_phase;
        n_retry   = r_retry;
        n_tick    = r_tick;
        o_res.command  = CMD_NONE;
        o_res.done_res = 1'b0;
        o_res.success  = 1'b0;

        unique case (i_item.operation)
            OP_START: begin
                if (r_phase == PH_IDLE) begin
                    n_retry = '0;
                    n_tick  = '0;
                    n_phase = PH_TXWAIT;
                    o_res.command = CMD_TX;
                end
            end
            OP_TICK: begin
                if (r_phase == PH_ACKWIN) begin
                    n_tick = tick_inc;
                    if (win_hit) begin
                        do_fail  = 1'b1;
                        base_cmd = CMD_STANDBY;
                    end
                end else if (r_phase == PH_GAP) begin
                    n_tick = tick_inc;
                    if (gap_hit) begin
                        n_tick  = '0;
                        n_phase = PH_TXWAIT;
                        o_res.command = CMD_TX;
                    end
                end
            end
            OP_TX_RES: begin
                if (r_phase == PH_TXWAIT) begin
                    if (i_item.tx_ok) begin
                        n_tick  = '0;
                        n_phase = PH_ACKWIN;
                        o_res.command = CMD_RX;
                    end else begin
                        do_fail  = 1'b1;
                        base_cmd = CMD_NONE;
                    end
                end
            end
            OP_RX_PKT: begin
                if (r_phase == PH_ACKWIN) begin
                    if (is_ack) begin
                        n_phase = PH_IDLE;
                        n_tick  = '0;
                        o_res.command  = CMD_STANDBY;
                        o_res.done_res = 1'b1;
                        o_res.success  = 1'b1;
                    end else begin
                        o_res.command = CMD_RX;
                    end
                end
            end
            default: ;
        endcase

        // Failed attempt: give up or schedule a retry
        if (do_fail) begin
            n_tick = '0;
            o_res.command = base_cmd;
            if (exhausted) begin
                n_phase = PH_IDLE;
                o_res.done_res = 1'b1;
            end else begin
                n_retry = r_retry + 1'b1;
                if (i_cfg.retry_gap_ticks == '0) begin
                    n_phase = PH_TXWAIT;
                    o_res.command = CMD_TX;
                end else begin
                    n_phase = PH_GAP;
                end
            end
        end

        o_res.attempt = ATTEMPT_W'(n_retry);
    end

    // State update on each event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_retry <= '0;
            r_tick  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_retry <= n_retry;
            r_tick  <= n_tick;
        end
    end

endmodule

`default_nettype wire

### design/arq_chk.sv
`default_nettype none
`include "assert_macros.svh"

module arq_chk
    import arq_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_out_stall,
    input wire logic                 o_out_valid,
    input wire logic [CMD_W-1:0]     o_command,
    input wire logic                 o_done_res,
    input wire logic                 o_success,
    input wire logic [ATTEMPT_W-1:0] o_attempt
);

    // Result word as seen on the ports, and short terms for the checks
    logic [CMD_W+ATTEMPT_W+1:0] out_word;
    logic                       out_held;
    logic                       out_won;
    logic                       out_lost;
    logic                       quiet_cmd;

    assign out_word  = {o_command, o_done_res, o_success, o_attempt};
    assign out_held  = o_out_valid && i_out_stall;
    assign out_won   = o_out_valid && o_success;
    assign out_lost  = o_out_valid && o_done_res && !o_success;
    assign quiet_cmd = (o_command == CMD_NONE) || (o_command == CMD_STANDBY);

    // A stalled result word stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

    // Success only comes with done and a standby order
    `ASSERT_IMPLY(a_success_done, i_clk, i_rst_n, out_won, o_done_res && (o_command == CMD_STANDBY))

    // Giving up never orders a transmit or receive
    `ASSERT_IMPLY(a_fail_cmd, i_clk, i_rst_n, out_lost, quiet_cmd)

    // A receive order never closes the exchange
    `ASSERT_IMPLY(a_rx_open, i_clk, i_rst_n, o_out_valid && (o_command == CMD_RX), !o_done_res)

endmodule

bind ack_retry_transmit_controller arq_chk u_arq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_command   (o_command),
    .o_done_res  (o_done_res),
    .o_success   (o_success),
    .o_attempt   (o_attempt)
);

`default_nettype wire
